/* rtl/pgge_pkg.sv */
// pgge_pkg: shared types, register indexes and the gray expansion function
// for the packed glyph gray expander. No dependencies.
package pgge_pkg;

	// source pixel formats
	typedef enum logic [1:0] {
		MODE_MONO  = 2'd0,
		MODE_GRAY2 = 2'd1,
		MODE_GRAY4 = 2'd2,
		MODE_GRAY8 = 2'd3
	} pgge_mode_t;

	// configuration register indexes
	localparam logic [1:0] CFG_PIXEL_MODE   = 2'd0;
	localparam logic [1:0] CFG_ROW_WIDTH    = 2'd1;
	localparam logic [1:0] CFG_SOURCE_PITCH = 2'd2;

	localparam int CFG_DATA_W = 11;

	// one accepted byte that yields at least one pixel
	typedef struct packed {
		logic [7:0] data;
		pgge_mode_t mode;
		logic [3:0] count;    // pixels to emit, 1..8
		logic       row_flag; // last pixel of this byte ends the row
	} pgge_item_t;

	// expand the top field of a left-aligned byte to 8-bit gray
	function automatic logic [7:0] pgge_expand(pgge_mode_t mode, logic [7:0] s);
		logic [3:0] v4;
		logic [7:0] g;
		v4 = s[7:4];
		g  = '0;
		unique case (mode)
			MODE_MONO: g = {8{s[7]}};
			MODE_GRAY2: begin
				unique case (s[7:6])
					2'd0: g = 8'd0;
					2'd1: g = 8'd84;
					2'd2: g = 8'd169;
					2'd3: g = 8'd255;
				endcase
			end
			MODE_GRAY4: begin
				// 256*v/15 - 1 is 17*v - 1 below 15
				priority if (v4 == 4'd0) begin
					g = 8'd0;
				end else if (v4 == 4'd15) begin
					g = 8'd255;
				end else begin
					g = {v4, 4'b0000} + {4'b0000, v4} - 8'd1;
				end
			end
			MODE_GRAY8: g = s;
		endcase
		return g;
	endfunction

endpackage

/* rtl/pgge_front.sv */
// pgge_front: configuration registers and row position tracking; works out
// how many pixels each accepted byte yields. Depends on pgge_pkg.
module pgge_front #(
	parameter int MAX_ROW_PIXELS  = 1024,
	parameter int MAX_PITCH_BYTES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [pgge_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          accept,
	input  logic [7:0]                    src_byte,
	output logic                          item_load,
	output pgge_pkg::pgge_item_t          item
);
	import pgge_pkg::*;

	localparam int PW  = $clog2(MAX_ROW_PIXELS + 1);
	localparam int BW  = $clog2(MAX_PITCH_BYTES + 1);
	localparam int MW  = (PW > BW) ? PW : BW;
	localparam int CW  = ((MW > CFG_DATA_W) ? MW : CFG_DATA_W) + 1;

	pgge_mode_t              pixel_mode_q;
	logic [CFG_DATA_W-1:0]   row_width_q;
	logic [CFG_DATA_W-1:0]   source_pitch_q;
	logic [PW-1:0]           pixel_pos_q;
	logic [BW-1:0]           byte_pos_q;

	logic [CW-1:0] rw_x, ps_x, width_x, pitch_x;
	logic [PW-1:0] width, remaining;
	logic [BW-1:0] pitch;
	logic [3:0]    per_byte, count;
	logic          closes;

	assign cfg_ready = 1'b1;

	always_comb begin
		rw_x    = CW'(row_width_q);
		ps_x    = CW'(source_pitch_q);
		width_x = (rw_x > CW'(MAX_ROW_PIXELS)) ? CW'(MAX_ROW_PIXELS) : rw_x;
		priority if (ps_x == '0) begin
			pitch_x = CW'(1);
		end else if (ps_x > CW'(MAX_PITCH_BYTES)) begin
			pitch_x = CW'(MAX_PITCH_BYTES);
		end else begin
			pitch_x = ps_x;
		end
		width     = width_x[PW-1:0];
		pitch     = pitch_x[BW-1:0];
		remaining = (pixel_pos_q < width) ? (width - pixel_pos_q) : '0;
		per_byte  = 4'd8 >> pixel_mode_q;
		count     = (remaining >= PW'(per_byte)) ? per_byte : remaining[3:0];
		closes    = ({1'b0, byte_pos_q} + (BW+1)'(1)) >= {1'b0, pitch};
	end

	assign item_load     = accept && (count != 4'd0);
	assign item.data     = src_byte;
	assign item.mode     = pixel_mode_q;
	assign item.count    = count;
	assign item.row_flag = (remaining <= PW'(per_byte)) || closes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q   <= MODE_MONO;
			row_width_q    <= '0;
			source_pitch_q <= CFG_DATA_W'(1);
			pixel_pos_q    <= '0;
			byte_pos_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_PIXEL_MODE:   pixel_mode_q   <= pgge_mode_t'(cfg_data[1:0]);
					CFG_ROW_WIDTH:    row_width_q    <= cfg_data;
					CFG_SOURCE_PITCH: source_pitch_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (closes) begin
					pixel_pos_q <= '0;
					byte_pos_q  <= '0;
				end else begin
					pixel_pos_q <= pixel_pos_q + PW'(count);
					byte_pos_q  <= byte_pos_q + BW'(1);
				end
			end
		end
	end

endmodule

/* rtl/pgge_unpack.sv */
// pgge_unpack: byte holding stage, pixel counter and output register;
// emits one expanded pixel per cycle unless pix_stall holds the output register. Depends on pgge_pkg.
module pgge_unpack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_load,
	input  pgge_pkg::pgge_item_t item,
	output logic                 busy_stall,
	output logic                 pix_valid,
	input  logic                 pix_stall,
	output logic [7:0]           gray_level,
	output logic                 last_of_byte,
	output logic                 row_end
);
	import pgge_pkg::*;

	pgge_item_t item_s1;
	logic       valid_s1;
	logic [2:0] pix_idx_q;
	logic       out_valid_q;
	logic [7:0] gray_q;
	logic       last_q, rend_q;

	logic       adv, last_pix;
	logic [2:0] shamt;
	logic [7:0] field;

	assign adv        = valid_s1 && (!out_valid_q || !pix_stall);
	assign last_pix   = ({1'b0, pix_idx_q} + 4'd1) == item_s1.count;
	assign busy_stall = valid_s1 && !(adv && last_pix);
	assign shamt      = 3'(pix_idx_q << item_s1.mode);
	assign field      = item_s1.data << shamt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pix_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_load) begin
				valid_s1  <= 1'b1;
				pix_idx_q <= '0;
			end else if (adv) begin
				if (last_pix) begin
					valid_s1 <= 1'b0;
				end
				pix_idx_q <= pix_idx_q + 3'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_load) begin
			item_s1 <= item;
		end
		if (adv) begin
			gray_q <= pgge_expand(item_s1.mode, field);
			last_q <= last_pix;
			rend_q <= last_pix && item_s1.row_flag;
		end
	end

	assign pix_valid    = out_valid_q;
	assign gray_level   = gray_q;
	assign last_of_byte = last_q;
	assign row_end      = rend_q;

endmodule

/* rtl/packed_glyph_gray_expander_unit.sv */
// packed_glyph_gray_expander_unit: top level of the packed bitmap to 8-bit
// gray expander. Depends on pgge_pkg, pgge_front and pgge_unpack.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   src      | src_valid / src_stall  | src_byte
//   pix      | pix_valid / pix_stall  | gray_level, last_of_byte, row_end
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each source byte yields 8, 4, 2 or 1 pixels (mono, 2bpp, 4bpp, 8bpp),
// fewer at a row's end, none for padding; the output register moves one
// pixel per cycle unless pix_stall holds it, and a byte holds the unpack
// stage until its last pixel moves on. A transaction on src is taken in
// the cycle its predecessor hands over its last pixel. Padding bytes do
// not enter the unpack stage. A byte's first pixel passes the holding
// stage and then the output register, which it enters once that is free.
// arst_n clears the configuration to its defaults and the row positions.
// pix_stall holds the output register and, through it, src.
module packed_glyph_gray_expander_unit #(
	parameter int MAX_ROW_PIXELS  = 1024,
	parameter int MAX_PITCH_BYTES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [pgge_pkg::CFG_DATA_W-1:0] cfg_data,
	// source bytes
	input  logic                            src_valid,
	output logic                            src_stall,
	input  logic [7:0]                      src_byte,
	// gray pixels
	output logic                            pix_valid,
	input  logic                            pix_stall,
	output logic [7:0]                      gray_level,
	output logic                            last_of_byte,
	output logic                            row_end
);
	import pgge_pkg::*;

	logic       accept;
	logic       item_load;
	pgge_item_t item;

	// a byte transaction completes when valid meets a free unpack stage
	assign accept = src_valid && !src_stall;

	// positions, counts and row-end flag per byte
	pgge_front #(
		.MAX_ROW_PIXELS (MAX_ROW_PIXELS),
		.MAX_PITCH_BYTES(MAX_PITCH_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.src_byte (src_byte),
		.item_load(item_load),
		.item     (item)
	);

	// per-pixel serialization and output register
	pgge_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_load   (item_load),
		.item        (item),
		.busy_stall  (src_stall),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.gray_level  (gray_level),
		.last_of_byte(last_of_byte),
		.row_end     (row_end)
	);

endmodule

/* rtl/pgge_checker.sv */
// pgge_checker: port-level assertions for packed_glyph_gray_expander_unit,
// bound to the top level below. No dependencies.
module pgge_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       src_valid,
	input logic       src_stall,
	input logic [7:0] src_byte,
	input logic       pix_valid,
	input logic       pix_stall,
	input logic [7:0] gray_level,
	input logic       last_of_byte,
	input logic       row_end
);

	// a stalled pixel holds its value
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(gray_level)
			&& $stable(last_of_byte) && $stable(row_end))
		else $error("stalled pixel changed");

	// a row can only end on the last pixel of a byte
	a_rend_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && row_end |-> last_of_byte)
		else $error("row_end without last_of_byte");

	// output restarts only after a byte transaction has passed the holding stage and output register
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_valid) |-> $past(src_valid && !src_stall, 2))
		else $error("pixel without a source byte");

	// configuration writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

	// a stalled source byte stays offered and unchanged
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_byte))
		else $error("stalled source byte changed");

endmodule

bind packed_glyph_gray_expander_unit pgge_checker u_pgge_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.src_valid   (src_valid),
	.src_stall   (src_stall),
	.src_byte    (src_byte),
	.pix_valid   (pix_valid),
	.pix_stall   (pix_stall),
	.gray_level  (gray_level),
	.last_of_byte(last_of_byte),
	.row_end     (row_end)
);

/* tb/packed_glyph_gray_expander_unit_test.sv */
`timescale 1ns / 100ps
// Testbench for packed_glyph_gray_expander_unit: drives source bytes and
// register writes, predicts every gray pixel and checks the pixel stream.
// Depends on pgge_pkg and the expander RTL.
module packed_glyph_gray_expander_unit_test;
	import pgge_pkg::*;

	localparam int MAX_ROW   = 1024;
	localparam int MAX_PITCH = 1024;

	// one predicted output pixel
	typedef struct packed {
		logic [7:0] gray;
		logic       last;
		logic       rend;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_PIXEL_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [7:0]  src_byte = 8'h00;
	logic        pix_valid;
	logic        pix_stall = 1'b0;
	logic [7:0]  gray_level;
	logic        last_of_byte;
	logic        row_end;

	// shadow of the register file and the row counters
	pgge_mode_t      mode_set;
	logic [10:0]     width_set;
	logic [10:0]     pitch_set;
	int              row_pixel_count;
	int              row_byte_count;

	pixel_t          pixels_due[$];   // expected pixels, oldest first
	pixel_t          oldest_due;
	int              yielding_bytes;  // accepted bytes that produced pixels
	int              mismatch_count;
	int unsigned     send_gap_pct;    // chance of a gap before each byte
	int unsigned     recv_stall_pct;  // chance of stalling a pixel

	packed_glyph_gray_expander_unit #(
		.MAX_ROW_PIXELS (MAX_ROW),
		.MAX_PITCH_BYTES(MAX_PITCH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_byte    (src_byte),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.gray_level  (gray_level),
		.last_of_byte(last_of_byte),
		.row_end     (row_end)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// gray value of one source field of the given format
	function automatic logic [7:0] gray_of(pgge_mode_t m, int v);
		case (m)
			MODE_MONO:  return (v != 0) ? 8'd255 : 8'd0;
			MODE_GRAY2: return (v != 0) ? 8'(256 * v / 3 - 1) : 8'd0;
			MODE_GRAY4: return (v != 0) ? 8'(256 * v / 15 - 1) : 8'd0;
			default:    return 8'(v);
		endcase
	endfunction

	// expand one accepted byte into its pixels and advance the row counters
	task automatic unpack_byte(input logic [7:0] b);
		int     eff_width;
		int     eff_pitch;
		int     bits;
		int     per;
		int     remaining;
		int     n;
		int     shift;
		int     v;
		bit     closes;
		pixel_t px;
		eff_width = (width_set > MAX_ROW) ? MAX_ROW : int'(width_set);
		if (pitch_set == 0)
			eff_pitch = 1;
		else
			eff_pitch = (pitch_set > MAX_PITCH) ? MAX_PITCH : int'(pitch_set);
		bits      = 1 << int'(mode_set);
		per       = 8 >> int'(mode_set);
		remaining = (row_pixel_count < eff_width) ? eff_width - row_pixel_count : 0;
		n         = (per < remaining) ? per : remaining;
		// the byte completing the pitch closes the row, even if it is padding
		closes    = (row_byte_count + 1) >= eff_pitch;
		for (int k = 0; k < n; k++) begin
			shift   = 8 - bits * (k + 1);
			v       = int'(b >> shift) & ((1 << bits) - 1);
			px.gray = gray_of(mode_set, v);
			px.last = (k + 1 == n);
			// row end: width reached, or last pixel of the closing byte
			px.rend = (row_pixel_count + k + 1 == eff_width) || (px.last && closes);
			pixels_due.push_back(px);
		end
		if (n > 0)
			yielding_bytes++;
		if (closes) begin
			row_pixel_count = 0;
			row_byte_count  = 0;
		end else begin
			row_pixel_count += n;
			row_byte_count  += 1;
		end
	endtask

	// ------------------------------------------------------------------
	// Pixel side: random stall, and check of every accepted transaction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && pix_valid === 1'b1 && pix_stall === 1'b0) begin
			if (pixels_due.size() == 0) begin
				$display("%0t: pixel with nothing expected: gray %0d last %0b row_end %0b",
					$time, gray_level, last_of_byte, row_end);
				mismatch_count++;
			end else begin
				oldest_due = pixels_due.pop_front();
				if (gray_level !== oldest_due.gray)
					$display("%0t: gray_level expected %0d actual %0d",
						$time, oldest_due.gray, gray_level);
				if (last_of_byte !== oldest_due.last)
					$display("%0t: last_of_byte expected %0b actual %0b",
						$time, oldest_due.last, last_of_byte);
				if (row_end !== oldest_due.rend)
					$display("%0t: row_end expected %0b actual %0b",
						$time, oldest_due.rend, row_end);
				if (gray_level !== oldest_due.gray || last_of_byte !== oldest_due.last ||
				    row_end !== oldest_due.rend)
					mismatch_count++;
			end
		end
		pix_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// Shared drivers; every task starts and ends just after a rising edge
	// ------------------------------------------------------------------

	// one source byte transaction, with a random gap in front of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_byte  <= b;
		do
			@(posedge clk);
		while (!(src_valid && !src_stall));
		unpack_byte(b);
	endtask

	// one register write transaction; the shadow copy follows at the handshake
	task automatic write_reg(input logic [1:0] index, input logic [10:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (index)
			CFG_PIXEL_MODE:   mode_set  = pgge_mode_t'(data[1:0]);
			CFG_ROW_WIDTH:    width_set = data;
			CFG_SOURCE_PITCH: pitch_set = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and let every predicted pixel come out; padding bytes
	// leave no trace in the queue, so the task waits on after the queue empties
	task automatic wait_idle();
		src_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input pgge_mode_t mode, input logic [10:0] width,
	                          input logic [10:0] pitch);
		wait_idle();
		write_reg(CFG_PIXEL_MODE, {9'd0, mode});
		write_reg(CFG_ROW_WIDTH, width);
		write_reg(CFG_SOURCE_PITCH, pitch);
	endtask

	// random byte, leaning on all-zero and all-one patterns now and then
	function automatic logic [7:0] rand_byte();
		if ($urandom_range(7) == 0)
			return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset state: width 0 and pitch 1, so every byte is padding
	task automatic test_reset_defaults();
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h5A);
	endtask

	task automatic test_mono();
		set_config(MODE_MONO, 11'd8, 11'd1);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h5A);
	endtask

	// all four two-bit levels in both orders
	task automatic test_gray2();
		set_config(MODE_GRAY2, 11'd4, 11'd1);
		send_byte(8'h1B);
		send_byte(8'hE4);
		send_byte(8'hFF);
	endtask

	// every four-bit level once
	task automatic test_gray4();
		set_config(MODE_GRAY4, 11'd2, 11'd1);
		for (int i = 0; i < 8; i++)
			send_byte(8'((2 * i) << 4 | (2 * i + 1)));
	endtask

	task automatic test_gray8();
		set_config(MODE_GRAY8, 11'd4, 11'd4);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h7F);
	endtask

	// partial last group and a padding byte, then a width beyond what
	// the pitch can hold so the closing byte carries the row end
	task automatic test_partial_rows();
		set_config(MODE_MONO, 11'd11, 11'd3);
		send_byte(8'hFF);
		send_byte(8'hE0);
		send_byte(8'hAA);
		set_config(MODE_MONO, 11'd20, 11'd2);
		send_byte(8'hFF);
		send_byte(8'h0F);
	endtask

	// pitch 0 behaves as pitch 1
	task automatic test_zero_pitch();
		set_config(MODE_GRAY4, 11'd3, 11'd0);
		send_byte(8'h9C);
		send_byte(8'h31);
	endtask

	// registers rewritten in the middle of a row keep the row counters
	task automatic test_midrow_change();
		set_config(MODE_GRAY8, 11'd6, 11'd6);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		wait_idle();
		write_reg(CFG_ROW_WIDTH, 11'd2);    // already past the new width
		send_byte(8'h44);
		wait_idle();
		write_reg(CFG_SOURCE_PITCH, 11'd2); // already past the new pitch
		send_byte(8'h55);
		send_byte(8'h66);
		send_byte(8'h77);
	endtask

	// oversized width clamps to 1024 pixels
	task automatic test_register_clamps();
		set_config(MODE_MONO, 11'd2047, 11'd130);
		repeat (131) send_byte(rand_byte());
	endtask

	// random register settings, mostly whole rows, sometimes a partial row
	// left open for the next setting to pick up
	task automatic test_random_rows(input int target);
		int         goal;
		int         per;
		int         width;
		int         pitch;
		int         eff_pitch;
		int         count;
		pgge_mode_t mode;
		goal = yielding_bytes + target;
		while (yielding_bytes < goal) begin
			mode = pgge_mode_t'($urandom_range(3));
			per  = 8 >> int'(mode);
			if ($urandom_range(99) < 8) begin
				width = $urandom_range(1025, 2047);
				pitch = $urandom_range(1, 6);
			end else begin
				width = $urandom_range(0, 24);
				if ($urandom_range(99) < 15)
					pitch = $urandom_range(0, 5);
				else
					pitch = (width + per - 1) / per + $urandom_range(0, 2);
			end
			eff_pitch = (pitch == 0) ? 1 : pitch;
			wait_idle();
			// unused upper bits of the mode write must be ignored
			write_reg(CFG_PIXEL_MODE, {9'($urandom_range(511)), mode});
			write_reg(CFG_ROW_WIDTH, 11'(width));
			write_reg(CFG_SOURCE_PITCH, 11'(pitch));
			count = eff_pitch * $urandom_range(1, 4);
			if ($urandom_range(3) == 0)
				count += $urandom_range(1, eff_pitch);
			repeat (count) send_byte(rand_byte());
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		mode_set        = MODE_MONO;
		width_set       = '0;
		pitch_set       = 11'd1;
		row_pixel_count = 0;
		row_byte_count  = 0;
		yielding_bytes  = 0;
		mismatch_count  = 0;
		send_gap_pct    = 9;
		recv_stall_pct  = 87;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_mono();
		test_gray2();
		test_gray4();
		test_gray8();
		test_partial_rows();
		test_zero_pitch();
		test_midrow_change();
		test_register_clamps();

		test_random_rows(80);
		wait_idle();
		send_gap_pct   = 87;
		recv_stall_pct = 9;
		test_random_rows(80);
		wait_idle();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_random_rows(80);

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pixels_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/pgge_pkg.sv
rtl/pgge_front.sv
rtl/pgge_unpack.sv
rtl/packed_glyph_gray_expander_unit.sv
rtl/pgge_checker.sv
tb/packed_glyph_gray_expander_unit_test.sv
